// ----- rtl/bbsg_pkg.sv -----
// Shared types, constants and small helpers for the bytebeat sample generator.
// No dependencies; used by every module of the block.
package bbsg_pkg;

  // Divider digits retired per pipeline stage and divider datapath widths.
  localparam int STEP_BITS = 8;
  localparam int REM_W     = 10;  // remainder, divisor is at most 1024
  localparam int DSR_W     = 11;  // divisor

  // Register indexes on the APB port (byte address bits [3:2]).
  localparam logic [1:0] REG_FORMULA = 2'd0;
  localparam logic [1:0] REG_KNOB_A  = 2'd1;
  localparam logic [1:0] REG_KNOB_B  = 2'd2;

  // Formula codes held in the formula register.
  localparam logic [3:0] FML_0 = 4'd0;
  localparam logic [3:0] FML_1 = 4'd1;
  localparam logic [3:0] FML_2 = 4'd2;
  localparam logic [3:0] FML_3 = 4'd3;
  localparam logic [3:0] FML_4 = 4'd4;
  localparam logic [3:0] FML_5 = 4'd5;
  localparam logic [3:0] FML_6 = 4'd6;
  localparam logic [3:0] FML_7 = 4'd7;
  localparam logic [3:0] FML_8 = 4'd8;
  localparam logic [3:0] FML_9 = 4'd9;

  typedef struct packed {
    logic [3:0] formula;
    logic [3:0] knob_a;
    logic [3:0] knob_b;
  } cfg_t;

  // Byte-wide operands prepared by the front stage for the final combine.
  typedef struct packed {
    logic [7:0] t8;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
  } lane_t;

  // Running state of the long divider.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [7:0]       quo;  // last eight quotient bits
    logic [DSR_W-1:0] divisor;
  } div_t;

  // Knob divided by five, knob in 0..15.
  function automatic logic [1:0] div5(input logic [3:0] v);
    logic [1:0] r;
    if (v >= 4'd15) r = 2'd3;
    else if (v >= 4'd10) r = 2'd2;
    else if (v >= 4'd5) r = 2'd1;
    else r = 2'd0;
    return r;
  endfunction

endpackage

// ----- rtl/bbsg_front.sv -----
// Front stage: decodes the formula, does the wide shifts and subtracts and
// sets up the divider. Depends on bbsg_pkg.
module bbsg_front #(
  parameter int TIME_BITS = 32,
  parameter int DIV_W     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bbsg_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [31:0]           time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bbsg_pkg::lane_t       lane_o,
  output bbsg_pkg::div_t        div_o,
  output logic [DIV_W-1:0]      dividend_o
);

  localparam logic [31:0] TMASK32 = (TIME_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << TIME_BITS) - 64'd1);

  logic                  valid_q;
  bbsg_pkg::lane_t       lane_d, lane_q;
  bbsg_pkg::div_t        div_d, div_q;
  logic [DIV_W-1:0]      dvd_d, dvd_q;

  always_comb begin
    logic [31:0]          t;
    logic [2:0]           a2, b2;
    logic [1:0]           b5;
    logic [31:0]          s3, v3, d5;
    logic [7:0]           y8;
    logic [TIME_BITS-1:0] yw, xw;

    t  = time_i & TMASK32;
    a2 = cfg_i.knob_a[3:1];
    b2 = cfg_i.knob_b[3:1];
    b5 = bbsg_pkg::div5(cfg_i.knob_b);

    // data-dependent shift: shift amount is itself a shifted time index
    s3 = t >> (5'd16 - 5'(a2));
    v3 = (s3 >= 32'd32) ? 32'd0 : (t >> s3[4:0]);

    // wrap the difference at the time width before shifting down
    d5 = t - (32'd1280 - 32'(a2));
    y8 = 8'((((d5 ^ t) & TMASK32)) >> (5'd10 - 5'(b5)));

    yw = TIME_BITS'(t >> 9);
    xw = yw ^ (yw - TIME_BITS'(4'd1 + 4'(a2))) ^ TIME_BITS'(1);

    lane_d       = '0;
    lane_d.t8    = t[7:0];
    div_d.rem    = '0;
    div_d.quo    = '0;
    div_d.divisor = bbsg_pkg::DSR_W'(11'd1024 - 11'(b2));
    dvd_d        = DIV_W'(t);

    unique case (cfg_i.formula)
      bbsg_pkg::FML_0: begin
        lane_d.p0 = 8'(t >> 7);
        lane_d.p1 = 8'(t >> (5'd10 - 5'(b5)));
      end
      bbsg_pkg::FML_1: begin
        lane_d.p0 = 8'(t | (t >> (5'd9 + 5'(a2))) | (t >> 7));
        lane_d.p1 = 8'((t >> (5'd11 + 5'(b2))) | (t >> 9));
      end
      bbsg_pkg::FML_2: begin
        lane_d.p0 = 8'(t >> 4);
        lane_d.p1 = 8'(t >> (5'd7 + 5'(a2)));
      end
      bbsg_pkg::FML_3: begin
        lane_d.p0 = 8'((t >> 6) | t | v3);
        lane_d.p1 = 8'(t >> 11) & (8'd7 + 8'(b2));
      end
      bbsg_pkg::FML_4: begin
        lane_d.p0 = 8'(t >> (5'd11 - 5'(b2))) & 8'(t >> 8) &
                    (8'd123 - 8'(cfg_i.knob_a)) & 8'(t >> 3);
      end
      bbsg_pkg::FML_5: begin
        lane_d.p0 = t[7:0] ^ (t[7:0] + (8'(t >> 15) | 8'd1)) ^ y8;
      end
      bbsg_pkg::FML_6: begin
        lane_d.p0 = 8'(t >> 8) & 8'(cfg_i.knob_b) & 8'(t >> 4);
      end
      bbsg_pkg::FML_7: begin
        lane_d.p0 = 8'(t & (t >> (5'd12 + 5'(a2))));
        lane_d.p1 = 8'((t >> 4) | (t >> (5'd8 - 5'(b2))));
        lane_d.p2 = 8'(t >> 6);
      end
      bbsg_pkg::FML_8: begin
        div_d.divisor = bbsg_pkg::DSR_W'(11'd13 + 11'(b2));
        dvd_d         = DIV_W'(xw);
      end
      bbsg_pkg::FML_9: begin
        lane_d.p0 = (8'(t >> (5'd12 + 5'(a2))) | 8'(t >> 8)) &
                    (8'd63 - 8'(b2)) & 8'(t >> 4);
      end
      default: ;  // silent formula codes
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      lane_q <= lane_d;
      div_q  <= div_d;
      dvd_q  <= dvd_d;
    end
  end

  assign out_valid_o = valid_q;
  assign lane_o      = lane_q;
  assign div_o       = div_q;
  assign dividend_o  = dvd_q;

endmodule

// ----- rtl/bbsg_div_stage.sv -----
// One divider stage: eight restoring-division steps on the top dividend byte.
// Depends on bbsg_pkg.
module bbsg_div_stage #(
  parameter int DIV_W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DIV_W-1:0]      dividend_i,
  input  bbsg_pkg::div_t        div_i,
  input  bbsg_pkg::lane_t       lane_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIV_W-1:0]      dividend_o,
  output bbsg_pkg::div_t        div_o,
  output bbsg_pkg::lane_t       lane_o
);

  logic                  valid_q;
  bbsg_pkg::div_t        div_d, div_q;
  bbsg_pkg::lane_t       lane_q;
  logic [DIV_W-1:0]      dvd_q;

  always_comb begin
    logic [bbsg_pkg::STEP_BITS-1:0] bits;
    logic [bbsg_pkg::REM_W:0]       part;

    div_d = div_i;
    bits  = dividend_i[DIV_W-1 -: bbsg_pkg::STEP_BITS];
    for (int k = 0; k < bbsg_pkg::STEP_BITS; k++) begin
      part = {div_d.rem, bits[bbsg_pkg::STEP_BITS-1]};
      bits = bits << 1;
      if (part >= div_i.divisor) begin
        div_d.rem = bbsg_pkg::REM_W'(part - div_i.divisor);
        div_d.quo = {div_d.quo[6:0], 1'b1};
      end else begin
        div_d.rem = part[bbsg_pkg::REM_W-1:0];
        div_d.quo = {div_d.quo[6:0], 1'b0};
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      div_q  <= div_d;
      lane_q <= lane_i;
      dvd_q  <= dividend_i << bbsg_pkg::STEP_BITS;
    end
  end

  assign out_valid_o = valid_q;
  assign dividend_o  = dvd_q;
  assign div_o       = div_q;
  assign lane_o      = lane_q;

endmodule

// ----- rtl/bbsg_final.sv -----
// Final stage: byte-wide multiplies and the per-formula combine into the
// output register. Depends on bbsg_pkg.
module bbsg_final (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bbsg_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bbsg_pkg::lane_t       lane_i,
  input  bbsg_pkg::div_t        div_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            sample_o
);

  logic       valid_q;
  logic [7:0] sample_d, sample_q;

  always_comb begin
    logic [7:0] t8;
    logic [7:0] a5;

    t8 = lane_i.t8;
    a5 = 8'(bbsg_pkg::div5(cfg_i.knob_a));

    unique case (cfg_i.formula)
      bbsg_pkg::FML_0: sample_d = (8'(t8 * (8'd5 + a5)) & lane_i.p0) |
                                  (8'(t8 * 8'd3) & lane_i.p1);
      bbsg_pkg::FML_1: sample_d = 8'(lane_i.p0 * t8) & lane_i.p1;
      bbsg_pkg::FML_2: sample_d = ((8'(t8 * 8'd9) & lane_i.p0) |
                                   (8'(t8 * 8'd5) & lane_i.p1) |
                                   (8'(t8 * 8'd3) & div_i.quo)) - 8'd1;
      bbsg_pkg::FML_3: sample_d = 8'(lane_i.p0 * 8'd10) + lane_i.p1;
      bbsg_pkg::FML_4,
      bbsg_pkg::FML_5,
      bbsg_pkg::FML_6,
      bbsg_pkg::FML_9: sample_d = 8'(t8 * lane_i.p0);
      bbsg_pkg::FML_7: sample_d = 8'(lane_i.p0 * lane_i.p1) ^ lane_i.p2;
      bbsg_pkg::FML_8: sample_d = 8'(t8 * div_i.rem[7:0]);
      default:         sample_d = 8'd0;
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sample_o    = sample_q;

endmodule

// ----- rtl/bytebeat_sample_generator.sv -----
// Top level of the bytebeat sample generator: register port, pipeline chain.
// Depends on bbsg_pkg, bbsg_front, bbsg_div_stage and bbsg_final.
//
//  Port group | Dir | Payload                          | Handshake
//  s_axis     | in  | tdata[31:0] = time_index         | tvalid / tready
//  m_axis     | out | tdata[7:0]  = sample             | tvalid / tready
//  APB        | in  | formula 0x0, knob_a 0x4, knob_b 0x8 | psel / penable, pready = 1
//
// One item per cycle while m_axis_tready holds. Pipeline: one front
// stage, one long-divider stage per eight dividend bits, one output stage.
// The divider depth sets the latency; formula two needs a quotient and
// formula eight a remainder, both from the same divider chain.
// Reset clears the configuration registers and all stage valid bits; no clearing pass.
// Every stage holds its item while the next one is full, so a stall at the
// output only backs up as far as the first empty stage.
module bytebeat_sample_generator #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] time_index
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] sample
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DIV_STAGES = (TIME_BITS + 7) / 8;
  localparam int DIV_W      = DIV_STAGES * bbsg_pkg::STEP_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [3:0] formula_q, knob_a_q, knob_b_q;
  logic       apb_wr;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      formula_q <= 4'd0;
      knob_a_q  <= 4'd0;
      knob_b_q  <= 4'd0;
    end else if (apb_wr) begin
      unique case (paddr[3:2])
        bbsg_pkg::REG_FORMULA: formula_q <= pwdata[3:0];
        bbsg_pkg::REG_KNOB_A:  knob_a_q  <= pwdata[3:0];
        bbsg_pkg::REG_KNOB_B:  knob_b_q  <= pwdata[3:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bbsg_pkg::REG_FORMULA: prdata = {28'd0, formula_q};
      bbsg_pkg::REG_KNOB_A:  prdata = {28'd0, knob_a_q};
      bbsg_pkg::REG_KNOB_B:  prdata = {28'd0, knob_b_q};
      default:               prdata = 32'd0;
    endcase
  end

  bbsg_pkg::cfg_t cfg;
  assign cfg.formula = formula_q;
  assign cfg.knob_a  = knob_a_q;
  assign cfg.knob_b  = knob_b_q;

  // ---------------------------------------------------------------------
  // Pipeline: front -> divider stages -> output
  // Index 0 is the front output, index DIV_STAGES the last divider output.
  // stg_ready[i] is the ready of whatever consumes stage i.
  // ---------------------------------------------------------------------
  logic [DIV_STAGES:0] stg_valid;
  logic [DIV_STAGES:0] stg_ready;
  bbsg_pkg::lane_t     stg_lane [DIV_STAGES+1];
  bbsg_pkg::div_t      stg_div  [DIV_STAGES+1];
  logic [DIV_W-1:0]    stg_dvd  [DIV_STAGES+1];

  bbsg_front #(
    .TIME_BITS (TIME_BITS),
    .DIV_W     (DIV_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .time_i      (s_axis_tdata),
    .out_valid_o (stg_valid[0]),
    .out_ready_i (stg_ready[0]),
    .lane_o      (stg_lane[0]),
    .div_o       (stg_div[0]),
    .dividend_o  (stg_dvd[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    bbsg_div_stage #(
      .DIV_W (DIV_W)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[g]),
      .in_ready_o  (stg_ready[g]),
      .dividend_i  (stg_dvd[g]),
      .div_i       (stg_div[g]),
      .lane_i      (stg_lane[g]),
      .out_valid_o (stg_valid[g+1]),
      .out_ready_i (stg_ready[g+1]),
      .dividend_o  (stg_dvd[g+1]),
      .div_o       (stg_div[g+1]),
      .lane_o      (stg_lane[g+1])
    );
  end

  bbsg_final u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (stg_valid[DIV_STAGES]),
    .in_ready_o  (stg_ready[DIV_STAGES]),
    .lane_i      (stg_lane[DIV_STAGES]),
    .div_i       (stg_div[DIV_STAGES]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (m_axis_tdata)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  logic [DIV_STAGES+1:0] vld_vec;
  logic                  in_acc, out_acc;

  assign vld_vec = {m_axis_tvalid, stg_valid};
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // a drained or draining output must let the input side in
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output side is free");

  // items in flight change only by accepted items on either side
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> ($countones(vld_vec) + int'($past(out_acc)) ==
                $past($countones(vld_vec)) + int'($past(in_acc))))
    else $error("item lost or duplicated in pipeline");

  a_knob_b_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apb_wr && paddr[3:2] == bbsg_pkg::REG_KNOB_B) |=>
    (knob_b_q == $past(pwdata[3:0])))
    else $error("knob_b write not taken");

endmodule

// ----- bench/bbsg_sample_checker.sv -----
// Checker for the bytebeat sample generator: tracks register writes, predicts
// each sample and compares it with the output stream. Depends on bbsg_pkg.
`timescale 1ns / 100ps

module bbsg_sample_checker #(
  parameter logic [3:0] FORMULA_ADDR = 4'h0,
  parameter logic [3:0] KNOB_A_ADDR  = 4'h4,
  parameter logic [3:0] KNOB_B_ADDR  = 4'h8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int                 TIME_W = 32;
  localparam logic [63:0]        TMASK  = 64'hFFFF_FFFF;

  typedef struct {
    logic [31:0] time_index;
    logic [7:0]  sample;
  } sample_exp_t;

  bbsg_pkg::cfg_t regs_shadow;
  sample_exp_t    sample_q[$];
  sample_exp_t    oldest;
  int             mismatches;

  assign fail_count_o = mismatches;

  // right shift that gives 0 once the amount reaches the word width
  function automatic logic [63:0] shr_w(input logic [63:0] a, input logic [63:0] s);
    if (s >= TIME_W) return 64'd0;
    return (a & TMASK) >> s;
  endfunction

  function automatic logic [63:0] wrap(input logic [63:0] v);
    return v & TMASK;
  endfunction

  function automatic logic [7:0] bytebeat_sample(input logic [31:0] t_in,
                                                 input bbsg_pkg::cfg_t c);
    logic [63:0] t, a, b, x, y, r;
    t = {32'd0, t_in};
    a = {60'd0, c.knob_a};
    b = {60'd0, c.knob_b};
    case (c.formula)
      bbsg_pkg::FML_0: r = (wrap(t * (5 + a / 5)) & shr_w(t, 7)) |
                           (wrap(t * 3) & shr_w(t, 10 - b / 5));
      bbsg_pkg::FML_1: begin
        x = wrap((t | shr_w(t, 9 + a / 2) | shr_w(t, 7)) * t);
        r = x & (shr_w(t, 11 + b / 2) | shr_w(t, 9));
      end
      bbsg_pkg::FML_2: begin
        x = (wrap(t * 9) & shr_w(t, 4)) |
            (wrap(t * 5) & shr_w(t, 7 + a / 2)) |
            (wrap(t * 3) & (t / (1024 - b / 2)));
        r = wrap(x - 1);
      end
      bbsg_pkg::FML_3: begin
        // inner shift amount can reach 32 and above: wide shift gives 0
        x = shr_w(t, 6) | t | shr_w(t, shr_w(t, 16 - a / 2));
        r = wrap(wrap(x * 10) + (shr_w(t, 11) & (7 + b / 2)));
      end
      bbsg_pkg::FML_4: begin
        x = shr_w(t, 11 - b / 2) & shr_w(t, 8) & ((123 - a) & shr_w(t, 3));
        r = wrap(t * x);
      end
      bbsg_pkg::FML_5: begin
        y = shr_w(wrap(t - (1280 - a / 2)) ^ t, 10 - b / 5);
        x = t ^ wrap(t + (shr_w(t, 15) | 1)) ^ y;
        r = wrap(t * x);
      end
      bbsg_pkg::FML_6: r = wrap(t * (shr_w(t, 8) & b & shr_w(t, 4)));
      bbsg_pkg::FML_7: begin
        x = wrap((t & shr_w(t, 12 + a / 2)) * (shr_w(t, 4) | shr_w(t, 8 - b / 2)));
        r = x ^ shr_w(t, 6);
      end
      bbsg_pkg::FML_8: begin
        y = shr_w(t, 9);
        x = y ^ wrap(y - (1 + a / 2)) ^ 1;
        r = wrap(t * (x % (13 + b / 2)));
      end
      bbsg_pkg::FML_9: begin
        x = (shr_w(t, 12 + a / 2) | shr_w(t, 8)) & ((63 - b / 2) & shr_w(t, 4));
        r = wrap(t * x);
      end
      default: r = 64'd0;  // unused formula numbers are silent
    endcase
    return r[7:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_shadow = '0;
      sample_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          FORMULA_ADDR: regs_shadow.formula = pwdata_i[3:0];
          KNOB_A_ADDR:  regs_shadow.knob_a  = pwdata_i[3:0];
          KNOB_B_ADDR:  regs_shadow.knob_b  = pwdata_i[3:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (sample_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected sample, expected none, got 0x%02h", $time, m_tdata_i);
        end else begin
          oldest = sample_q.pop_front();
          if (m_tdata_i !== oldest.sample) begin
            mismatches++;
            $display("%0t: time_index 0x%08h: expected sample 0x%02h, got 0x%02h",
                     $time, oldest.time_index, oldest.sample, m_tdata_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        sample_q.push_back('{s_tdata_i, bytebeat_sample(s_tdata_i, regs_shadow)});
      pending_o <= sample_q.size();
    end
  end

endmodule

// ----- bench/tb_bytebeat_sample_generator.sv -----
// Top of the bytebeat sample generator bench: clock, reset, register and
// stream stimulus, verdict. Depends on bbsg_pkg, the block and bbsg_sample_checker.
`timescale 1ns / 100ps

module tb_bytebeat_sample_generator;

  // Register map, byte addresses on the APB port
  localparam logic [3:0] ADDR_FORMULA  = {bbsg_pkg::REG_FORMULA, 2'b00};
  localparam logic [3:0] ADDR_KNOB_A   = {bbsg_pkg::REG_KNOB_A, 2'b00};
  localparam logic [3:0] ADDR_KNOB_B   = {bbsg_pkg::REG_KNOB_B, 2'b00};
  localparam logic [3:0] ADDR_UNMAPPED = 4'hC;  // past the last register, must be ignored

  localparam int LATENCY      = (32 + 7) / 8 + 2;
  localparam int SETTLE       = 2 * LATENCY;
  localparam int RAND_PHASES  = 20;
  localparam int PHASE_ITEMS  = 85;
  localparam int CORNERS      = 11;
  localparam int KNOB_MAX     = 15;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic [31:0] s_tdata   = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // Flow-control knobs, percent of cycles spent idle (sender) or stalled (receiver)
  int idle_pct  = 0;
  int stall_pct = 0;

  int items_sent;
  int settings_used;

  // Time indices that hit the edges of the formulas: zero, top bit,
  // the divisor of formula two, the wide inner shift of formula three, etc.
  logic [31:0] corner_times [CORNERS] = '{
    32'h0000_0000, 32'h8000_0000, 32'h0000_0400, 32'h0020_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFF0, 32'h7FFF_FFFF,
    32'h0000_0200, 32'h1234_5678, 32'h0000_0001
  };

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  bytebeat_sample_generator #(
    .TIME_BITS(32)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bbsg_sample_checker #(
    .FORMULA_ADDR (ADDR_FORMULA),
    .KNOB_A_ADDR  (ADDR_KNOB_A),
    .KNOB_B_ADDR  (ADDR_KNOB_B)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver backpressure: one fresh draw per cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Setup then access cycle; upper data bits are noise the block must drop.
  // Ends with one idle cycle so back-to-back writes never touch psel twice
  // in the same step.
  task automatic reg_write(input logic [3:0] addr, input logic [3:0] value);
    logic [31:0] noise;
    noise = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {noise[31:4], value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= noise[0];
    @(posedge clk);
  endtask

  // Wait until every item in flight has come out, then a little more.
  // pending is registered in the checker, so a zero here is never stale
  // against an item accepted at the previous edge.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [3:0] fml, input logic [3:0] ka,
                               input logic [3:0] kb);
    wait_drained();
    reg_write(ADDR_FORMULA, fml);
    reg_write(ADDR_KNOB_A, ka);
    reg_write(ADDR_KNOB_B, kb);
    settings_used++;
  endtask

  // One item on the input stream, with a random gap in front of it.
  // tvalid stays high between back-to-back items.
  task automatic send_time(input logic [31:0] t);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom();
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    logic [3:0]  fml, ka, kb;
    logic [31:0] run_t;
    int          run_left;
    int          mode;

    items_sent    = 0;
    settings_used = 0;
    run_left      = 0;
    run_t         = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed part ----------------
    // Reset values first (formula zero, knobs zero), with a write to the
    // unmapped address in between that must leave them alone.
    reg_write(ADDR_UNMAPPED, 4'hF);
    send_time(32'hFFFF_FFFF);
    s_tvalid <= 1'b0;

    // Every formula plus one silent number, knobs at opposite extremes
    for (int f = 0; f < CORNERS; f++) begin
      fml = f[3:0];
      ka  = f[0] ? 4'(KNOB_MAX) : 4'd0;
      kb  = f[0] ? 4'd0 : 4'(KNOB_MAX);
      apply_setting(fml, ka, kb);
      send_time(32'hFFFF_FFFF);
      send_time(corner_times[f]);
      s_tvalid <= 1'b0;
    end

    // ---------------- random part ----------------
    // Each phase: one register setting, one flow-control mode. Phases walk
    // all sixteen formula numbers first, then random formulas.
    for (int p = 0; p < RAND_PHASES; p++) begin
      fml = (p < 16) ? p[3:0] : 4'($urandom_range(9));
      case (p % 5)
        0: begin ka = 4'd0;          kb = 4'd0;          end
        1: begin ka = 4'(KNOB_MAX);  kb = 4'(KNOB_MAX);  end
        2: begin ka = 4'd0;          kb = 4'(KNOB_MAX);  end
        3: begin ka = 4'(KNOB_MAX);  kb = 4'd0;          end
        default: begin
          ka = 4'($urandom_range(KNOB_MAX));
          kb = 4'($urandom_range(KNOB_MAX));
        end
      endcase
      apply_setting(fml, ka, kb);

      mode = p % 4;
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase

      // Mostly counter runs, as a real time source feeds the block; some
      // start low so the time-dependent shifts act on small time indices,
      // the rest are lone random words.
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (run_left == 0) begin
          case ($urandom_range(2))
            0: begin
              run_t    = $urandom();
              run_left = $urandom_range(40, 4);
            end
            1: begin
              run_t    = $urandom_range(32'h003F_FFFF);
              run_left = $urandom_range(40, 4);
            end
            default: begin
              run_t    = $urandom();
              run_left = 1;
            end
          endcase
        end
        send_time(run_t);
        run_t++;
        run_left--;
      end
      s_tvalid <= 1'b0;
    end

    idle_pct  = 0;
    stall_pct = 0;
    wait_drained();

    $display("run covered %0d time indices under %0d register settings,",
             items_sent, settings_used);
    $display("all formula numbers, knob extremes, four flow-control modes");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
